// ===== rtl/breit_wigner_amplitude_core_defines.svh =====
// Assertion macros used by the RTL queue; clk and rst_n must be in scope at each use.
`ifndef BREIT_WIGNER_AMPLITUDE_CORE_DEFINES_SVH
`define BREIT_WIGNER_AMPLITUDE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define BWA_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
`define BWA_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define BWA_ASSERT_IMPLY(lbl, ante, cons)
`define BWA_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ===== rtl/bwa_pkg.sv =====
package bwa_pkg;

  localparam int IN_FRAC_BITS  = 16;
  localparam int OUT_FRAC_BITS = 16;
  localparam int ALIGN_FRAC    = 48;

  localparam int SW        = 53;  // s, signed
  localparam int SQ_OPW    = 52;  // root operand
  localparam int SQ_STEPS  = SQ_OPW / 2;
  localparam int RTW       = SQ_OPW / 2;
  localparam int REMW      = RTW + 2;
  localparam int MW        = 68;  // aligned magnitudes
  localparam int AW        = 31;  // normalized magnitudes
  localparam int KW        = 6;
  localparam int DW        = 63;
  localparam int NW        = 96;
  localparam int QW        = 33;
  localparam int DIV_STEPS = QW;
  localparam int QDEPTH    = 4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_NEG  = 2'd2;
  localparam logic [1:0] ST_ZERO = 2'd3;

  localparam logic REG_MASS  = 1'b0;
  localparam logic REG_WIDTH = 1'b1;

  typedef struct packed {
    logic signed [23:0] positron_energy;
    logic signed [23:0] positron_px;
    logic signed [23:0] positron_py;
    logic signed [23:0] positron_pz;
    logic signed [23:0] electron_energy;
    logic signed [23:0] electron_px;
    logic signed [23:0] electron_py;
    logic signed [23:0] electron_pz;
    logic signed [23:0] proton_energy;
    logic signed [23:0] proton_px;
    logic signed [23:0] proton_py;
    logic signed [23:0] proton_pz;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] amplitude_real;
    logic signed [31:0] amplitude_imag;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic neg;
    logic zero;
    logic aneg;
    logic sat_a;
    logic sat_b;
  } flags_t;

  typedef struct packed {
    logic [SQ_OPW-1:0] val;
    logic [REMW-1:0]   rem;
    logic [RTW-1:0]    root;
    logic              neg;
  } sq_st_t;

  typedef struct packed {
    logic [NW-1:0] rem_a;
    logic [NW-1:0] rem_b;
    logic [QW-1:0] q_a;
    logic [QW-1:0] q_b;
    logic [DW-1:0] d;
    flags_t        flags;
  } div_st_t;

  function automatic logic [6:0] bit_len(input logic [MW-1:0] x);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < MW; i++) begin
      if (x[i]) n = 7'(i + 1);
    end
    return n;
  endfunction

endpackage

// ===== rtl/breit_wigner_amplitude_core.sv =====
// Relativistic Breit-Wigner amplitude engine. Each input beat carries the
// positron, electron and recoil-proton four-vectors (24-bit signed, 16
// fraction bits); each output beat carries 1/(s - M^2 + i*Gamma*sqrt(s)) as
// 32-bit signed real and imaginary parts with 16 fraction bits, plus a status
// code: ok, saturated, negative s (amplitude zero) or zero denominator
// (amplitude zero). M and Gamma are programmed over the APB-style port
// (offset 0x0 mass, 0x4 width, unsigned with 24 fraction bits); write them
// only while no beat is in flight. The block takes one beat per clock while
// in_stall is low and returns one result beat per clock in order while
// out_stall is low. A front section forms the summed four-vector and s in
// two stages, then a four-entry queue decouples it from the back section,
// which stalls only on out_stall. The datapath runs through the 26-stage
// square root pipeline, six alignment, normalize, square and setup stages,
// and the 33-stage restoring divider that produces both quotients side by
// side. in_stall rises only once the queue is full behind a stalled output.
module breit_wigner_amplitude_core import bwa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] mass_r, width_r;
  logic        cfg_wr;

  logic                 q_push, q_pop, q_full, q_not_empty;
  logic signed [SW-1:0] q_wdata, q_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Decode on the word offset; the byte lanes within a word alias.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_r  <= '0;
      width_r <= '0;
    end else if (cfg_wr && (paddr[1:0] == 2'b00 || paddr[1:0] != 2'b00)) begin
      unique case (paddr[2])
        REG_MASS:  mass_r  <= pwdata;
        REG_WIDTH: width_r <= pwdata;
        default:   ;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_WIDTH) ? width_r : mass_r;

  bwa_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  bwa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .not_empty (q_not_empty)
  );

  bwa_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_rdata     (q_rdata),
    .q_not_empty (q_not_empty),
    .q_pop       (q_pop),
    .mass        (mass_r),
    .width       (width_r),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

// ===== rtl/bwa_front.sv =====
module bwa_front import bwa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  input  logic                 q_full,
  output logic                 q_push,
  output logic signed [SW-1:0] q_wdata
);

  logic signed [25:0] e_r, px_r, py_r, pz_r;
  logic [50:0] e2_r, px2_r, py2_r, pz2_r;
  logic v1_r, v2_r;
  logic en;
  logic signed [51:0] e_sq, px_sq, py_sq, pz_sq;

  assign en       = !(v2_r && q_full);
  assign in_stall = !en;
  assign q_push   = v2_r && !q_full;

  assign e_sq  = e_r * e_r;
  assign px_sq = px_r * px_r;
  assign py_sq = py_r * py_r;
  assign pz_sq = pz_r * pz_r;

  assign q_wdata = {2'b00, e2_r} - {2'b00, px2_r} - {2'b00, py2_r} - {2'b00, pz2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r  <= 26'(in_data.positron_energy) + 26'(in_data.electron_energy)
            + 26'(in_data.proton_energy);
      px_r <= 26'(in_data.positron_px) + 26'(in_data.electron_px) + 26'(in_data.proton_px);
      py_r <= 26'(in_data.positron_py) + 26'(in_data.electron_py) + 26'(in_data.proton_py);
      pz_r <= 26'(in_data.positron_pz) + 26'(in_data.electron_pz) + 26'(in_data.proton_pz);
      e2_r  <= e_sq[50:0];
      px2_r <= px_sq[50:0];
      py2_r <= py_sq[50:0];
      pz2_r <= pz_sq[50:0];
    end
  end

endmodule

// ===== rtl/bwa_queue.sv =====
`include "breit_wigner_amplitude_core_defines.svh"

module bwa_queue import bwa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic signed [SW-1:0] wdata,
  output logic                 full,
  input  logic                 pop,
  output logic signed [SW-1:0] rdata,
  output logic                 not_empty
);

  localparam int PW = $clog2(QDEPTH);

  logic signed [SW-1:0] mem [QDEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   count_r;

  assign full      = (count_r == (PW+1)'(QDEPTH));
  assign not_empty = (count_r != '0);
  assign rdata     = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  `BWA_ASSERT_IMPLY(a_no_overflow, push, !full)
  `BWA_ASSERT_IMPLY(a_no_underflow, pop, not_empty)
  `BWA_ASSERT_NEVER(a_count_range, count_r > (PW+1)'(QDEPTH))

endmodule

// ===== rtl/bwa_isqrt.sv =====
module bwa_isqrt import bwa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SQ_OPW-1:0] in_val,
  input  logic              in_neg,
  output logic              out_valid,
  output logic [SQ_OPW-1:0] out_val,
  output logic              out_neg,
  output logic [RTW-1:0]    out_root
);

  sq_st_t st_r   [SQ_STEPS];
  sq_st_t st_nxt [SQ_STEPS];
  logic [SQ_STEPS-1:0] vld_r;

  // One result bit per stage, two operand bits brought down each time.
  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_step
    sq_st_t p;
    logic [REMW+1:0] rem_sh, trial;
    logic ge;
    if (g == 0) begin : g_first
      assign p = '{val: in_val, rem: '0, root: '0, neg: in_neg};
    end else begin : g_next
      assign p = st_r[g-1];
    end
    assign rem_sh = {p.rem, p.val[SQ_OPW-1-2*g -: 2]};
    assign trial  = {2'b00, p.root, 2'b01};
    assign ge     = (rem_sh >= trial);
    assign st_nxt[g] = '{val:  p.val,
                         rem:  ge ? REMW'(rem_sh - trial) : REMW'(rem_sh),
                         root: {p.root[RTW-2:0], ge},
                         neg:  p.neg};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[SQ_STEPS-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < SQ_STEPS; i++) st_r[i] <= st_nxt[i];
    end
  end

  assign out_valid = vld_r[SQ_STEPS-1];
  assign out_val   = st_r[SQ_STEPS-1].val;
  assign out_neg   = st_r[SQ_STEPS-1].neg;
  assign out_root  = st_r[SQ_STEPS-1].root;

endmodule

// ===== rtl/bwa_divider.sv =====
module bwa_divider import bwa_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  logic    in_valid,
  input  div_st_t in_data,
  output logic    out_valid,
  output div_st_t out_data
);

  div_st_t st_r   [DIV_STEPS];
  div_st_t st_nxt [DIV_STEPS];
  logic [DIV_STEPS-1:0] vld_r;

  // Two restoring lanes share the divisor; one quotient bit each per stage.
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
    div_st_t p;
    logic [NW-1:0] trial;
    logic ge_a, ge_b;
    if (g == 0) begin : g_first
      assign p = in_data;
    end else begin : g_next
      assign p = st_r[g-1];
    end
    assign trial = NW'(p.d) << (QW - 1 - g);
    assign ge_a  = (p.rem_a >= trial);
    assign ge_b  = (p.rem_b >= trial);
    assign st_nxt[g] = '{rem_a: ge_a ? p.rem_a - trial : p.rem_a,
                         rem_b: ge_b ? p.rem_b - trial : p.rem_b,
                         q_a:   {p.q_a[QW-2:0], ge_a},
                         q_b:   {p.q_b[QW-2:0], ge_b},
                         d:     p.d,
                         flags: p.flags};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[DIV_STEPS-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DIV_STEPS; i++) st_r[i] <= st_nxt[i];
    end
  end

  assign out_valid = vld_r[DIV_STEPS-1];
  assign out_data  = st_r[DIV_STEPS-1];

endmodule

// ===== rtl/bwa_back.sv =====
module bwa_back import bwa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic signed [SW-1:0] q_rdata,
  input  logic                 q_not_empty,
  output logic                 q_pop,
  input  logic [31:0]          mass,
  input  logic [31:0]          width,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data
);

  logic en;
  logic [63:0] m2_r;

  logic              sq_vld, sq_neg;
  logic [SQ_OPW-1:0] sq_val;
  logic [RTW-1:0]    sq_root;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  flags_t f1_r, f2_r, f3_r, f4_r, f5_r;
  logic [MW-1:0] amag1_r, amag2_r, bmag2_r;
  logic [57:0]   bprod1_r;
  logic [KW-1:0] k2_r, k3_r, k4_r;
  logic [AW-1:0] as3_r, bs3_r, as4_r, bs4_r;
  logic [61:0]   a2_4_r, b2_4_r;
  logic [DW-1:0] d5_r;
  logic [NW-1:0] na5_r, nb5_r;
  div_st_t       div_in_r, div_out;
  logic          div_vld;

  logic [MW-1:0] sw, mw, bmag_w;
  logic          aneg_w;
  logic [6:0]    bl;
  logic [6:0]    sh;
  logic [QW-1:0] lim_a, lim_b, mag_a, mag_b;
  logic          sat_a, sat_b;
  out_item_t     res;
  logic          out_valid_r;
  out_item_t     out_data_r;

  assign en    = !(out_valid_r && out_stall);
  assign q_pop = q_not_empty && en;

  always_ff @(posedge clk) begin
    m2_r <= 64'(mass) * 64'(mass);
  end

  bwa_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (q_pop),
    .in_val    (q_rdata[SQ_OPW-1:0]),
    .in_neg    (q_rdata[SW-1]),
    .out_valid (sq_vld),
    .out_val   (sq_val),
    .out_neg   (sq_neg),
    .out_root  (sq_root)
  );

  assign sw     = MW'(sq_val) << (ALIGN_FRAC - 2 * IN_FRAC_BITS);
  assign mw     = MW'(m2_r);
  assign aneg_w = (sw < mw);
  assign bmag_w = MW'(bprod1_r) << (24 - IN_FRAC_BITS);
  assign bl     = bit_len(amag1_r | bmag_w);
  assign sh     = 7'(ALIGN_FRAC + OUT_FRAC_BITS) - {1'b0, k4_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v1_r, v2_r, v3_r, v4_r, v5_r, v6_r} <= '0;
    end else if (en) begin
      {v1_r, v2_r, v3_r, v4_r, v5_r, v6_r} <= {sq_vld, v1_r, v2_r, v3_r, v4_r, v5_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // align a and b to a common fraction, form the width term
      amag1_r  <= aneg_w ? mw - sw : sw - mw;
      bprod1_r <= 58'(width) * 58'(sq_root);
      f1_r     <= '{neg: sq_neg, zero: 1'b0, aneg: aneg_w, sat_a: 1'b0, sat_b: 1'b0};
      // pick the normalizing shift from the larger magnitude
      amag2_r  <= amag1_r;
      bmag2_r  <= bmag_w;
      k2_r     <= (bl > 7'd31) ? KW'(bl - 7'd31) : '0;
      f2_r     <= '{neg: f1_r.neg, zero: (amag1_r == '0) && (bmag_w == '0),
                    aneg: f1_r.aneg, sat_a: 1'b0, sat_b: 1'b0};
      as3_r    <= AW'(amag2_r >> k2_r);
      bs3_r    <= AW'(bmag2_r >> k2_r);
      k3_r     <= k2_r;
      f3_r     <= f2_r;
      a2_4_r   <= 62'(as3_r) * 62'(as3_r);
      b2_4_r   <= 62'(bs3_r) * 62'(bs3_r);
      as4_r    <= as3_r;
      bs4_r    <= bs3_r;
      k4_r     <= k3_r;
      f4_r     <= f3_r;
      d5_r     <= DW'(a2_4_r) + DW'(b2_4_r);
      na5_r    <= NW'(as4_r) << sh;
      nb5_r    <= NW'(bs4_r) << sh;
      f5_r     <= f4_r;
      // a numerator at or above d * 2^QW saturates whatever the quotient
      div_in_r <= '{rem_a: na5_r, rem_b: nb5_r, q_a: '0, q_b: '0, d: d5_r,
                    flags: '{neg: f5_r.neg, zero: f5_r.zero, aneg: f5_r.aneg,
                             sat_a: na5_r >= (NW'(d5_r) << QW),
                             sat_b: nb5_r >= (NW'(d5_r) << QW)}};
    end
  end

  bwa_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v6_r),
    .in_data   (div_in_r),
    .out_valid (div_vld),
    .out_data  (div_out)
  );

  always_comb begin
    lim_a = div_out.flags.aneg ? QW'(32'h8000_0000) : QW'(32'h7FFF_FFFF);
    lim_b = QW'(32'h8000_0000);
    sat_a = div_out.flags.sat_a || (div_out.q_a > lim_a);
    sat_b = div_out.flags.sat_b || (div_out.q_b > lim_b);
    mag_a = sat_a ? lim_a : div_out.q_a;
    mag_b = sat_b ? lim_b : div_out.q_b;
    priority if (div_out.flags.neg) begin
      res = '{amplitude_real: '0, amplitude_imag: '0, status: ST_NEG};
    end else if (div_out.flags.zero) begin
      res = '{amplitude_real: '0, amplitude_imag: '0, status: ST_ZERO};
    end else begin
      res.amplitude_real = div_out.flags.aneg ? 32'(QW'(0) - mag_a) : 32'(mag_a);
      res.amplitude_imag = 32'(QW'(0) - mag_b);
      res.status         = (sat_a || sat_b) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= div_vld;
  end

  always_ff @(posedge clk) begin
    if (en) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== dv/tb_breit_wigner_amplitude_core.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the Breit-Wigner amplitude core. Events are queued
// by the stimulus process, pushed by a falling-edge driver with random gaps,
// and checked at the rising edge against an in-bench predictor of the exact
// fixed-point arithmetic.
module tb_breit_wigner_amplitude_core;
  import bwa_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int RANDOM_ITEMS   = 1750;

  localparam logic [2:0] ADDR_MASS  = 3'(REG_MASS * 4);
  localparam logic [2:0] ADDR_WIDTH = 3'(REG_WIDTH * 4);

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor copy of the two registers.
  logic [31:0] mass_q  = '0;
  logic [31:0] width_q = '0;

  in_item_t  event_q[$];
  out_item_t amp_expected_q[$];

  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  hold_off = 1'b0;
  int  hold_cycles = 0;
  bit  stim_done = 1'b0;
  bit  in_fire = 1'b0;

  breit_wigner_amplitude_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // Predict one result from an event and the current registers.
  function automatic out_item_t compute_amplitude(input in_item_t ev);
    logic signed [63:0]  e, px, py, pz, s;
    logic [63:0]         v, root, bitv, m2, d, a_s, b_s;
    logic [127:0]        sw, mw, amag, bmag, num, q;
    logic [63:0]         re_lim, im_lim, re, im;
    int                  abits, bbits, k, ex;
    bit                  aneg, sat;
    out_item_t           r;
    e  = 64'(ev.positron_energy) + 64'(ev.electron_energy) + 64'(ev.proton_energy);
    px = 64'(ev.positron_px) + 64'(ev.electron_px) + 64'(ev.proton_px);
    py = 64'(ev.positron_py) + 64'(ev.electron_py) + 64'(ev.proton_py);
    pz = 64'(ev.positron_pz) + 64'(ev.electron_pz) + 64'(ev.proton_pz);
    s  = e * e - px * px - py * py - pz * pz;
    r = '0;
    if (s < 0) begin
      r.status = ST_NEG;
      return r;
    end
    // Floor square root.
    v = s; root = 0; bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    m2 = 64'(mass_q) * 64'(mass_q);
    sw = 128'(s) << (ALIGN_FRAC - 2 * IN_FRAC_BITS);
    mw = 128'(m2);
    aneg = sw < mw;
    amag = aneg ? mw - sw : sw - mw;
    bmag = (128'(width_q) * 128'(root)) << (24 - IN_FRAC_BITS);
    if (amag == 0 && bmag == 0) begin
      r.status = ST_ZERO;
      return r;
    end
    abits = 0; bbits = 0;
    for (int i = 0; i < 128; i++) begin
      if (amag[i]) abits = i + 1;
      if (bmag[i]) bbits = i + 1;
    end
    if (bbits > abits) abits = bbits;
    k = abits > 31 ? abits - 31 : 0;
    a_s = 64'(amag >> k);
    b_s = 64'(bmag >> k);
    d = a_s * a_s + b_s * b_s;
    ex = ALIGN_FRAC + OUT_FRAC_BITS - k;
    sat = 1'b0;
    re_lim = aneg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    im_lim = 64'h8000_0000;
    num = amag >> k;
    num = ex >= 0 ? num << ex : num >> (-ex);
    q = num / 128'(d);
    if (q > 128'(re_lim)) begin
      sat = 1'b1; re = re_lim;
    end else begin
      re = 64'(q);
    end
    num = bmag >> k;
    num = ex >= 0 ? num << ex : num >> (-ex);
    q = num / 128'(d);
    if (q > 128'(im_lim)) begin
      sat = 1'b1; im = im_lim;
    end else begin
      im = 64'(q);
    end
    r.amplitude_real = aneg ? 32'(-re) : 32'(re);
    r.amplitude_imag = 32'(-im);
    r.status = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  // Random gap: mostly none, else a short one, now and then a long one.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // Record at the rising edge whether the offered beat was taken.
  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && !in_stall;
  end

  // Driver: present the next event at the falling edge; hold on stall.
  int  drv_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_fire) begin
        // hold the stalled beat
      end else if (in_valid && in_fire) begin
        amp_expected_q.push_back(compute_amplitude(in_data));
        drv_gap = pick_gap();
        if (drv_gap == 0 && event_q.size() > 0) begin
          in_data <= event_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end else if (drv_gap > 0) begin
        drv_gap--;
      end else if (event_q.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= event_q.pop_front();
      end
    end
  end

  // Receiver stall: random gaps, or a long hold-off when asked.
  int rcv_gap = 0;
  always @(negedge clk) begin
    if (hold_off) begin
      out_stall <= 1'b1;
    end else if (rcv_gap > 0) begin
      rcv_gap--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      rcv_gap = pick_gap();
      out_stall <= rcv_gap > 0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: compare each accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (amp_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat real=%0d imag=%0d status=%0d",
                   out_data.amplitude_real, out_data.amplitude_imag, out_data.status);
      end else begin
        want = amp_expected_q.pop_front();
        if (want.amplitude_real !== out_data.amplitude_real ||
            want.amplitude_imag !== out_data.amplitude_imag ||
            want.status !== out_data.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp real=%0d imag=%0d st=%0d, got real=%0d imag=%0d st=%0d",
                     want.amplitude_real, want.amplitude_imag, want.status,
                     out_data.amplitude_real, out_data.amplitude_imag, out_data.status);
        end
      end
    end
  end

  // Watchdog: count cycles with no beat accepted on either side and no hold-off.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("** breit_wigner_amplitude_core: FAILED **");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (pready) begin
      if (addr == ADDR_MASS) mass_q = data;
      else width_q = data;
    end
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Wait until the driver is empty and every prediction has been matched.
  task automatic drain();
    while (event_q.size() > 0 || in_valid || amp_expected_q.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic signed [23:0] rnd24();
    case ($urandom_range(0, 5))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'(signed'($urandom_range(0, 2047)) - 1024);
      default: return 24'($urandom);
    endcase
  endfunction

  // Mostly positive energies and smaller momenta, so s is usually >= 0.
  function automatic in_item_t rnd_event();
    in_item_t ev;
    ev = '0;
    if ($urandom_range(0, 4) == 0) begin
      ev = {12{rnd24()}};
      for (int i = 0; i < 12; i++) ev[i*24 +: 24] = rnd24();
    end else begin
      ev.positron_energy = 24'($urandom_range(0, 400000));
      ev.electron_energy = 24'($urandom_range(0, 400000));
      ev.proton_energy   = 24'($urandom_range(0, 400000));
      ev.positron_px = 24'(signed'($urandom_range(0, 200000)) - 100000);
      ev.positron_py = 24'(signed'($urandom_range(0, 200000)) - 100000);
      ev.positron_pz = 24'(signed'($urandom_range(0, 200000)) - 100000);
      ev.electron_px = 24'(signed'($urandom_range(0, 200000)) - 100000);
      ev.electron_py = 24'(signed'($urandom_range(0, 200000)) - 100000);
      ev.electron_pz = 24'(signed'($urandom_range(0, 200000)) - 100000);
      ev.proton_px   = 24'(signed'($urandom_range(0, 100000)) - 50000);
      ev.proton_py   = 24'(signed'($urandom_range(0, 100000)) - 50000);
      ev.proton_pz   = 24'(signed'($urandom_range(0, 100000)) - 50000);
    end
    return ev;
  endfunction

  initial begin
    in_item_t ev;
    logic [31:0] masses[4];
    logic [31:0] widths[4];
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zero denominator with both registers at reset, then extremes.
    event_q.push_back('0);
    ev = '0; ev.positron_energy = 24'sh010000;
    event_q.push_back(ev);                       // s = 1, M = Gamma = 0
    ev = '0; ev.positron_px = 24'sh010000;
    event_q.push_back(ev);                       // negative s
    event_q.push_back({12{24'sh7FFFFF}});
    event_q.push_back({12{24'sh800000}});
    ev = '0;
    ev.positron_energy = 24'sh7FFFFF; ev.electron_energy = 24'sh7FFFFF;
    ev.proton_energy = 24'sh7FFFFF;
    event_q.push_back(ev);                       // largest s
    ev = '0; ev.positron_energy = 24'sh000001;
    event_q.push_back(ev);                       // tiny s, huge amplitude
    event_q.push_back({12{24'sh555555}});
    event_q.push_back({12{24'shAAAAAA}});
    drain();

    write_reg(ADDR_MASS, 32'h0100_0000);         // M = 1 GeV
    write_reg(ADDR_WIDTH, 32'h0000_0000);
    ev = '0; ev.positron_energy = 24'sh010000;
    event_q.push_back(ev);                       // s = M^2, Gamma 0: zero denominator
    ev = '0; ev.positron_energy = 24'sh008000;
    event_q.push_back(ev);                       // below resonance, a negative
    ev = '0; ev.positron_energy = 24'sh020000;
    event_q.push_back(ev);
    drain();

    write_reg(ADDR_MASS, 32'hFFFF_FFFF);
    write_reg(ADDR_WIDTH, 32'hFFFF_FFFF);
    event_q.push_back({12{24'sh7FFFFF}});
    ev = '0; ev.positron_energy = 24'sh7FFFFF; ev.electron_energy = 24'sh7FFFFF;
    ev.proton_energy = 24'sh7FFFFF;
    event_q.push_back(ev);
    ev = '0; ev.positron_energy = 24'sh000001;
    event_q.push_back(ev);
    drain();

    // Long receiver hold-off while the sender keeps offering events.
    for (int i = 0; i < 120; i++) event_q.push_back(rnd_event());
    hold_off = 1'b1;
    for (hold_cycles = 0; hold_cycles < 300; hold_cycles++) @(posedge clk);
    hold_off = 1'b0;
    drain();

    masses = '{32'h0000_0000, 32'h0310_0000, 32'h0080_0000, 32'hFFFF_FFFF};
    widths = '{32'h0000_0000, 32'h0002_0000, 32'h0400_0000, 32'hFFFF_FFFF};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(ADDR_MASS, ph < 4 ? masses[ph] : $urandom);
      write_reg(ADDR_WIDTH, ph < 4 ? widths[3 - ph] : $urandom);
      for (int i = 0; i < RANDOM_ITEMS / 6; i++) event_q.push_back(rnd_event());
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && amp_expected_q.size() == 0)
      $display("** breit_wigner_amplitude_core: PASSED **");
    else
      $display("** breit_wigner_amplitude_core: FAILED **");
    $finish;
  end
endmodule
